>>> design/sawtc_pkg.sv
// shared constants, types and the control program of the write-through cache
package sawtc_pkg;

    // cache and memory geometry
    localparam int CACHE_LINES    = 8;
    localparam int WORDS_PER_LINE = 16;
    localparam int MEMORY_BLOCKS  = 16;
    localparam int WORD_BITS      = 32;

    localparam int LINE_BITS   = $clog2(CACHE_LINES);
    localparam int OFF_BITS    = $clog2(WORDS_PER_LINE);
    localparam int BLK_BITS    = $clog2(MEMORY_BLOCKS);
    localparam int SETS        = CACHE_LINES / 2;
    localparam int SET_BITS    = $clog2(SETS);
    localparam int LRAM_DEPTH  = CACHE_LINES * WORDS_PER_LINE;
    localparam int LRAM_ABITS  = LINE_BITS + OFF_BITS;
    localparam int STORE_DEPTH = MEMORY_BLOCKS * WORDS_PER_LINE;
    localparam int STORE_ABITS = BLK_BITS + OFF_BITS;

    // result field widths
    localparam int LINE_FIELD_BITS = 3;
    localparam int COUNT_BITS      = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // victim lfsr and backing store reset pattern
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam int          RESET_STEP = 10;

    // sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RH_RD    = 3'd1,
        ST_RH_EMIT  = 3'd2,
        ST_RM_ALLOC = 3'd3,
        ST_RM_FILL  = 3'd4,
        ST_RM_EMIT  = 3'd5,
        ST_WH       = 3'd6,
        ST_WM       = 3'd7
    } step_t;

    // how the step counter moves on
    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_GOTO     = 2'd1,
        JMP_DISPATCH = 2'd2,
        JMP_LOOP     = 2'd3
    } jump_t;

    // source of the result word
    typedef enum logic [1:0] {
        WSRC_LINE = 2'd0,
        WSRC_FILL = 2'd1,
        WSRC_VAL  = 2'd2
    } wsrc_t;

    // which hit/miss counter an access bumps
    typedef enum logic [1:0] {
        CNT_RH = 2'd0,
        CNT_RM = 2'd1,
        CNT_WH = 2'd2,
        CNT_WM = 2'd3
    } cnt_sel_t;

    // access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // one control word
    typedef struct packed {
        logic     accept;
        logic     alloc;
        logic     mem_rd;
        logic     fill_wr;
        logic     line_rd;
        logic     store_wr;
        logic     line_wr;
        logic     emit;
        wsrc_t    wsrc;
        cnt_sel_t csel;
        jump_t    jmp;
        step_t    target;
    } ctrl_t;

    // conditions the sequencer branches on
    typedef struct packed {
        logic in_valid;
        logic slot_free;
        logic opcode;
        logic hit;
        logic cnt_last;
    } seq_cond_t;

    // control program
    function automatic ctrl_t ucode_word(input step_t s);
        ctrl_t w;
        w = '0;
        case (s)
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.jmp    = JMP_DISPATCH;
            end
            ST_RH_RD:
            begin
                w.line_rd = 1'b1;
                w.jmp     = JMP_NEXT;
            end
            ST_RH_EMIT:
            begin
                w.emit   = 1'b1;
                w.wsrc   = WSRC_LINE;
                w.csel   = CNT_RH;
                w.jmp    = JMP_GOTO;
                w.target = ST_IDLE;
            end
            ST_RM_ALLOC:
            begin
                w.alloc  = 1'b1;
                w.mem_rd = 1'b1;
                w.jmp    = JMP_NEXT;
            end
            ST_RM_FILL:
            begin
                w.fill_wr = 1'b1;
                w.mem_rd  = 1'b1;
                w.jmp     = JMP_LOOP;
            end
            ST_RM_EMIT:
            begin
                w.fill_wr = 1'b1;
                w.emit    = 1'b1;
                w.wsrc    = WSRC_FILL;
                w.csel    = CNT_RM;
                w.jmp     = JMP_GOTO;
                w.target  = ST_IDLE;
            end
            ST_WH:
            begin
                w.store_wr = 1'b1;
                w.line_wr  = 1'b1;
                w.emit     = 1'b1;
                w.wsrc     = WSRC_VAL;
                w.csel     = CNT_WH;
                w.jmp      = JMP_GOTO;
                w.target   = ST_IDLE;
            end
            ST_WM:
            begin
                w.store_wr = 1'b1;
                w.emit     = 1'b1;
                w.wsrc     = WSRC_VAL;
                w.csel     = CNT_WM;
                w.jmp      = JMP_GOTO;
                w.target   = ST_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // backing store word before any write: offset plus ten times block
    function automatic logic [WORD_BITS-1:0] reset_word(input logic [STORE_ABITS-1:0] addr);
        logic [WORD_BITS-1:0] blk;
        logic [WORD_BITS-1:0] off;
        blk = WORD_BITS'(addr[STORE_ABITS-1:OFF_BITS]);
        off = WORD_BITS'(addr[OFF_BITS-1:0]);
        return off + blk * WORD_BITS'(RESET_STEP);
    endfunction

endpackage

>>> design/sawtc_seq.sv
// microcode sequencer: step counter, control store lookup and branching
module sawtc_seq
    import sawtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_cond_t cond,
    output ctrl_t     ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  hold;

    // control word of the current step
    always_comb
    begin
        ctrl = ucode_word(step_reg);
    end

    // next step: wait for an item or a free result slot, else branch
    always_comb
    begin
        hold      = (ctrl.accept && !cond.in_valid) || (ctrl.emit && !cond.slot_free);
        step_next = step_reg;
        if (!hold)
        begin
            case (ctrl.jmp)
                JMP_NEXT:
                    step_next = step_t'(step_reg + 3'd1);
                JMP_GOTO:
                    step_next = ctrl.target;
                JMP_DISPATCH:
                begin
                    if (cond.opcode == OP_WRITE)
                        step_next = cond.hit ? ST_WH : ST_WM;
                    else
                        step_next = cond.hit ? ST_RH_RD : ST_RM_ALLOC;
                end
                JMP_LOOP:
                    step_next = cond.cnt_last ? step_t'(step_reg + 3'd1) : step_reg;
                default:
                    step_next = ST_IDLE;
            endcase
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

>>> design/sawtc_store.sv
// backing word memory with per-word written flags over the reset pattern
module sawtc_store
    import sawtc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [STORE_ABITS-1:0] rd_addr,
    input  logic                   wr_en,
    input  logic [STORE_ABITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]   wr_data,
    output logic [WORD_BITS-1:0]   rd_data
);

    logic [WORD_BITS-1:0]   mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] written_reg;
    logic [WORD_BITS-1:0]   rd_word_reg;
    logic [WORD_BITS-1:0]   rd_pattern_reg;
    logic                   rd_written_reg;

    // memory array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_word_reg    <= mem[rd_addr];
            rd_pattern_reg <= reset_word(rd_addr);
        end
    end

    // written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_written_reg <= written_reg[rd_addr];
        end
    end

    // unwritten words read as the reset pattern
    assign rd_data = rd_written_reg ? rd_word_reg : rd_pattern_reg;

endmodule

>>> design/set_assoc_write_through_cache.sv
// Write-through cache with two-way or direct-mapped placement in front of a word memory.
// Access items come in on in_valid/in_ready (opcode, block_number, word_offset,
// write_value); one result item per access leaves on out_valid/out_ready.
// The placement register is written on cfg_valid/cfg_ready (cfg_data), always ready;
// the user must write it only while no access is in flight, which the block leaves
// unchecked. The cache contents are kept across a change. A microcoded sequencer walks
// one access at a time; in_ready is high in its idle step. A read hit reads the line
// word, a write writes through, and a read miss first fills all sixteen line words over
// the single backing memory port. The next access is accepted in the cycle after a
// result is loaded, even while that result waits: the output register holds it and the
// sequencer only stalls at the following access's result step until out_ready frees the
// slot. Reset empties the cache, zeroes the four counters, seeds the victim lfsr and
// makes every memory word read as its reset pattern at once (per-word written flags);
// there is no clearing pass, so the first access may be accepted right after reset.
module set_assoc_write_through_cache
    import sawtc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [BLK_BITS-1:0]         block_number,
    input  logic [OFF_BITS-1:0]         word_offset,
    input  logic signed [WORD_BITS-1:0] write_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        was_hit,
    output logic [LINE_FIELD_BITS-1:0]  line_used,
    output logic signed [WORD_BITS-1:0] read_word,
    output logic [COUNT_BITS-1:0]       read_hit_count,
    output logic [COUNT_BITS-1:0]       read_miss_count,
    output logic [COUNT_BITS-1:0]       write_hit_count,
    output logic [COUNT_BITS-1:0]       write_miss_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);

    ctrl_t     ctrl;
    seq_cond_t cond;

    logic                   mode_reg;
    logic                   op_reg;
    logic [BLK_BITS-1:0]    blk_reg;
    logic [OFF_BITS-1:0]    off_reg;
    logic [WORD_BITS-1:0]   val_reg;
    logic                   hit_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic [OFF_BITS-1:0]    cnt_reg;
    logic [OFF_BITS-1:0]    wr_idx_reg;
    logic [BLK_BITS-1:0]    tag_reg [CACHE_LINES];
    logic [CACHE_LINES-1:0] valid_reg;
    logic [15:0]            lfsr_reg;
    logic [3:0][COUNT_BITS-1:0] hm_cnt_reg;
    logic [3:0][COUNT_BITS-1:0] hm_cnt_next;
    logic [WORD_BITS-1:0]   fill_word_reg;
    logic [WORD_BITS-1:0]   line_mem [LRAM_DEPTH];
    logic [WORD_BITS-1:0]   line_rd_reg;

    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [LINE_FIELD_BITS-1:0] out_line_reg;
    logic [WORD_BITS-1:0]       out_word_reg;

    logic [CACHE_LINES-1:0] hit_vec;
    logic                   hit_any;
    logic [LINE_BITS-1:0]   hit_line;
    logic [LINE_BITS-1:0]   victim;
    logic [LINE_BITS-1:0]   way0;
    logic [LINE_BITS-1:0]   way1;
    logic                   lfsr_step;
    logic                   lfsr_fb;
    logic                   accept_fire;
    logic                   emit_fire;
    logic                   slot_free;
    logic [WORD_BITS-1:0]   store_rd_data;
    logic [WORD_BITS-1:0]   fill_word;
    logic [WORD_BITS-1:0]   word_sel;
    logic [LINE_BITS-1:0]   line_out;
    logic                   line_we;
    logic [LRAM_ABITS-1:0]  line_waddr;
    logic [WORD_BITS-1:0]   line_wdata;

    // sequencer
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cond.in_valid  = in_valid;
        cond.slot_free = slot_free;
        cond.opcode    = opcode;
        cond.hit       = hit_any;
        cond.cnt_last  = (cnt_reg == OFF_BITS'(WORDS_PER_LINE - 1));
    end

    sawtc_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    assign in_ready    = ctrl.accept;
    assign accept_fire = in_valid && ctrl.accept;
    assign emit_fire   = ctrl.emit && slot_free;
    assign cfg_ready   = 1'b1;

    // backing memory
    sawtc_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ctrl.mem_rd),
        .rd_addr ({blk_reg, cnt_reg}),
        .wr_en   (ctrl.store_wr),
        .wr_addr ({blk_reg, off_reg}),
        .wr_data (val_reg),
        .rd_data (store_rd_data)
    );

    // hit search over all lines, lowest matching line wins
    always_comb
    begin
        hit_line = '0;
        for (int i = 0; i < CACHE_LINES; i++)
            hit_vec[i] = valid_reg[i] && (tag_reg[i] == block_number);
        for (int i = CACHE_LINES - 1; i >= 0; i--)
            if (hit_vec[i])
                hit_line = LINE_BITS'(i);
    end

    assign hit_any = |hit_vec;

    // two-way victim: first invalid way, else the lfsr bit; direct-mapped: low block bits
    assign way0 = {blk_reg[SET_BITS-1:0], 1'b0};
    assign way1 = {blk_reg[SET_BITS-1:0], 1'b1};

    always_comb
    begin
        victim    = blk_reg[LINE_BITS-1:0];
        lfsr_step = 1'b0;
        if (mode_reg)
        begin
            if (!valid_reg[way0])
                victim = way0;
            else if (!valid_reg[way1])
                victim = way1;
            else
            begin
                victim    = {blk_reg[SET_BITS-1:0], lfsr_reg[0]};
                lfsr_step = 1'b1;
            end
        end
    end

    assign lfsr_fb = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];

    // access registers, loaded on accept; line overwritten on allocation
    always_ff @(posedge clk)
    begin
        if (accept_fire)
        begin
            op_reg   <= opcode;
            blk_reg  <= block_number;
            off_reg  <= word_offset;
            val_reg  <= write_value;
            hit_reg  <= hit_any;
            line_reg <= hit_line;
        end
        else if (ctrl.alloc)
            line_reg <= victim;
        if (ctrl.fill_wr && (wr_idx_reg == off_reg))
            fill_word_reg <= store_rd_data;
    end

    // control state: mode, fill counters, tags, valid bits, lfsr
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            cnt_reg    <= '0;
            wr_idx_reg <= '0;
            valid_reg  <= '0;
            lfsr_reg   <= LFSR_SEED;
            for (int i = 0; i < CACHE_LINES; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= cfg_data;
            if (accept_fire)
                cnt_reg <= '0;
            else if (ctrl.mem_rd)
            begin
                cnt_reg    <= cnt_reg + 1'b1;
                wr_idx_reg <= cnt_reg;
            end
            if (ctrl.alloc)
            begin
                valid_reg[victim] <= 1'b1;
                tag_reg[victim]   <= blk_reg;
                if (lfsr_step)
                    lfsr_reg <= {lfsr_fb, lfsr_reg[15:1]};
            end
        end
    end

    // line data memory: fill from backing store or write-hit update
    assign line_we    = ctrl.fill_wr || ctrl.line_wr;
    assign line_waddr = ctrl.fill_wr ? {line_reg, wr_idx_reg} : {line_reg, off_reg};
    assign line_wdata = ctrl.fill_wr ? store_rd_data : val_reg;

    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_waddr] <= line_wdata;
        if (ctrl.line_rd)
            line_rd_reg <= line_mem[{line_reg, off_reg}];
    end

    // saturating hit/miss counters, bumped when the result is loaded
    always_comb
    begin
        hm_cnt_next = hm_cnt_reg;
        if (emit_fire && (hm_cnt_reg[ctrl.csel] != COUNT_MAX))
            hm_cnt_next[ctrl.csel] = hm_cnt_reg[ctrl.csel] + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hm_cnt_reg <= '0;
        else
            hm_cnt_reg <= hm_cnt_next;
    end

    // result word and line
    assign fill_word = (wr_idx_reg == off_reg) ? store_rd_data : fill_word_reg;
    assign line_out  = ((op_reg == OP_WRITE) && !hit_reg) ? '0 : line_reg;

    always_comb
    begin
        case (ctrl.wsrc)
            WSRC_LINE: word_sel = line_rd_reg;
            WSRC_FILL: word_sel = fill_word;
            WSRC_VAL:  word_sel = val_reg;
            default:   word_sel = val_reg;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_hit_reg  <= hit_reg;
            out_line_reg <= LINE_FIELD_BITS'(line_out);
            out_word_reg <= word_sel;
        end
    end

    // counters change only when a result is loaded, so they travel with it
    assign out_valid        = out_valid_reg;
    assign was_hit          = out_hit_reg;
    assign line_used        = out_line_reg;
    assign read_word        = out_word_reg;
    assign read_hit_count   = hm_cnt_reg[CNT_RH];
    assign read_miss_count  = hm_cnt_reg[CNT_RM];
    assign write_hit_count  = hm_cnt_reg[CNT_WH];
    assign write_miss_count = hm_cnt_reg[CNT_WM];

    // checks
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer still idle after taking an item");

    a_single_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> $onehot0(hit_vec))
        else $error("block held in more than one line");

    a_alloc_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.alloc |=> valid_reg[line_reg])
        else $error("allocated line not marked valid");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !emit_fire |=> $stable(hm_cnt_reg))
        else $error("counter moved without a result");

endmodule

>>> bench/testbench.sv
// self-checking testbench for the set-associative write-through cache
module testbench
    import sawtc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 150;
    localparam int HOLD_AT_ITEM  = 100;
    localparam int PHASE_ITEMS   = 86;
    localparam int RANDOM_PHASES = 5;
    localparam int DRAIN_CYCLES  = 30;

    // one result item as seen on the output ports
    typedef struct packed {
        logic                       hit;
        logic [LINE_FIELD_BITS-1:0] line;
        logic [WORD_BITS-1:0]       word;
        logic [COUNT_BITS-1:0]      rd_hits;
        logic [COUNT_BITS-1:0]      rd_misses;
        logic [COUNT_BITS-1:0]      wr_hits;
        logic [COUNT_BITS-1:0]      wr_misses;
    } access_result_t;

    // mirror of cache and memory contents, with the results still owed
    class cache_mirror;
        bit                    two_way;
        logic [WORD_BITS-1:0]  memory_words [MEMORY_BLOCKS][WORDS_PER_LINE];
        logic [WORD_BITS-1:0]  line_data [CACHE_LINES][WORDS_PER_LINE];
        logic [BLK_BITS-1:0]   line_tag [CACHE_LINES];
        bit                    line_ok [CACHE_LINES];
        logic [15:0]           victim_bits;
        logic [COUNT_BITS-1:0] tally [4];
        access_result_t        awaited [$];
        int                    mismatches;

        function new();
            two_way = 1'b1;
            for (int b = 0; b < MEMORY_BLOCKS; b++)
                for (int j = 0; j < WORDS_PER_LINE; j++)
                    memory_words[b][j] = WORD_BITS'(j + RESET_STEP * b);
            for (int i = 0; i < CACHE_LINES; i++)
            begin
                line_ok[i]  = 1'b0;
                line_tag[i] = '0;
                for (int j = 0; j < WORDS_PER_LINE; j++)
                    line_data[i][j] = '0;
            end
            victim_bits = LFSR_SEED;
            foreach (tally[k])
                tally[k] = '0;
            mismatches = 0;
        endfunction

        function void bump(cnt_sel_t k);
            if (tally[k] != COUNT_MAX)
                tally[k] = tally[k] + 1'b1;
        endfunction

        // line to fill on a read miss
        function int pick_line(logic [BLK_BITS-1:0] blk);
            int  base;
            logic fb;
            if (!two_way)
                return int'(blk) % CACHE_LINES;
            base = (int'(blk) % SETS) * 2;
            if (!line_ok[base])
                return base;
            if (!line_ok[base + 1])
                return base + 1;
            fb = victim_bits[0] ^ victim_bits[2] ^ victim_bits[3] ^ victim_bits[5];
            base = base + int'(victim_bits[0]);
            victim_bits = {fb, victim_bits[15:1]};
            return base;
        endfunction

        // work out the result of one accepted access
        function void note_access(logic op, logic [BLK_BITS-1:0] blk,
                                  logic [OFF_BITS-1:0] off, logic [WORD_BITS-1:0] val);
            int             found;
            int             line;
            access_result_t r;
            found = -1;
            line  = 0;
            for (int i = CACHE_LINES - 1; i >= 0; i--)
                if (line_ok[i] && line_tag[i] == blk)
                    found = i;
            if (op == OP_READ)
            begin
                if (found >= 0)
                begin
                    line = found;
                    bump(CNT_RH);
                end
                else
                begin
                    line = pick_line(blk);
                    line_ok[line]  = 1'b1;
                    line_tag[line] = blk;
                    for (int j = 0; j < WORDS_PER_LINE; j++)
                        line_data[line][j] = memory_words[blk][j];
                    bump(CNT_RM);
                end
                r.word = line_data[line][off];
            end
            else
            begin
                if (found >= 0)
                begin
                    line = found;
                    line_data[line][off] = val;
                    for (int j = 0; j < WORDS_PER_LINE; j++)
                        memory_words[blk][j] = line_data[line][j];
                    bump(CNT_WH);
                end
                else
                begin
                    memory_words[blk][off] = val;
                    bump(CNT_WM);
                end
                r.word = val;
            end
            r.hit       = (found >= 0);
            r.line      = LINE_FIELD_BITS'(line);
            r.rd_hits   = tally[CNT_RH];
            r.rd_misses = tally[CNT_RM];
            r.wr_hits   = tally[CNT_WH];
            r.wr_misses = tally[CNT_WM];
            awaited.push_back(r);
        endfunction

        function void flag_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0h, got %0h at %0t",
                             name, want, got, $realtime);
            end
        endfunction

        // compare one result item with the oldest one owed
        function void check_result(access_result_t got);
            access_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with nothing outstanding at %0t", $realtime);
                return;
            end
            want = awaited.pop_front();
            flag_field("was_hit", want.hit, got.hit);
            flag_field("line_used", want.line, got.line);
            flag_field("read_word", want.word, got.word);
            flag_field("read_hit_count", want.rd_hits, got.rd_hits);
            flag_field("read_miss_count", want.rd_misses, got.rd_misses);
            flag_field("write_hit_count", want.wr_hits, got.wr_hits);
            flag_field("write_miss_count", want.wr_misses, got.wr_misses);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        opcode;
    logic [BLK_BITS-1:0]         block_number;
    logic [OFF_BITS-1:0]         word_offset;
    logic signed [WORD_BITS-1:0] write_value;
    logic                        out_valid;
    logic                        out_ready;
    logic                        was_hit;
    logic [LINE_FIELD_BITS-1:0]  line_used;
    logic signed [WORD_BITS-1:0] read_word;
    logic [COUNT_BITS-1:0]       read_hit_count;
    logic [COUNT_BITS-1:0]       read_miss_count;
    logic [COUNT_BITS-1:0]       write_hit_count;
    logic [COUNT_BITS-1:0]       write_miss_count;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic                        cfg_data;

    cache_mirror mirror;
    int          quiet_cycles = 0;

    set_assoc_write_through_cache uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .block_number     (block_number),
        .word_offset      (word_offset),
        .write_value      (write_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .was_hit          (was_hit),
        .line_used        (line_used),
        .read_word        (read_word),
        .read_hit_count   (read_hit_count),
        .read_miss_count  (read_miss_count),
        .write_hit_count  (write_hit_count),
        .write_miss_count (write_miss_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // offer one access item, sometimes with a random gap before it
    task automatic send_access(logic op, logic [BLK_BITS-1:0] blk,
                               logic [OFF_BITS-1:0] off, logic [WORD_BITS-1:0] val);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode       <= op;
        block_number <= blk;
        word_offset  <= off;
        write_value  <= val;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.note_access(op, blk, off, val);
    endtask

    // random access, mostly crowding one set so that hits and evictions both occur
    task automatic random_access(int focus);
        logic                 op;
        logic [BLK_BITS-1:0]  blk;
        logic [WORD_BITS-1:0] val;
        op  = ($urandom_range(0, 9) < 6) ? OP_READ : OP_WRITE;
        if ($urandom_range(0, 3) == 0)
            blk = BLK_BITS'($urandom_range(0, MEMORY_BLOCKS - 1));
        else
            blk = BLK_BITS'(($urandom_range(0, 3) << 2) | (focus & 3));
        case ($urandom_range(0, 7))
            0:       val = {1'b1, {(WORD_BITS - 1){1'b0}}};
            1:       val = {1'b0, {(WORD_BITS - 1){1'b1}}};
            2:       val = '1;
            default: val = $urandom;
        endcase
        send_access(op, blk, OFF_BITS'($urandom_range(0, WORDS_PER_LINE - 1)), val);
    endtask

    // wait until every owed result has been taken
    task automatic wait_drained();
        while (mirror.awaited.size() != 0)
            @(posedge clk);
    endtask

    // change placement mode while no access is in flight
    task automatic set_mode(logic m);
        in_valid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror.two_way = m;
    endtask

    // result side: random stalls, and one long hold so the block backs up
    initial
    begin
        int             gap;
        int             taken;
        access_result_t got;
        taken = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            if (taken == HOLD_AT_ITEM)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got = {was_hit, line_used, read_word, read_hit_count, read_miss_count,
                   write_hit_count, write_miss_count};
            mirror.check_result(got);
            taken++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // reset, directed accesses, then random phases across both modes
    initial
    begin
        mirror = new();
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_READ;
        block_number <= '0;
        word_offset  <= '0;
        write_value  <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two-way: fills, hits, lfsr victims, write hit and miss, extreme values
        set_mode(1'b1);
        send_access(OP_READ, 4'd0, 4'd0, 32'h0);
        send_access(OP_READ, 4'd0, 4'd15, 32'h0);
        send_access(OP_READ, 4'd4, 4'd3, 32'hFFFF_FFFF);
        send_access(OP_READ, 4'd8, 4'd7, 32'h0);
        send_access(OP_READ, 4'd12, 4'd0, 32'h0);
        send_access(OP_WRITE, 4'd15, 4'd15, 32'h7FFF_FFFF);
        send_access(OP_READ, 4'd15, 4'd15, 32'h0);
        send_access(OP_WRITE, 4'd15, 4'd0, 32'h8000_0000);
        send_access(OP_WRITE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_access(OP_READ, 4'd15, 4'd0, 32'h0);
        send_access(OP_WRITE, 4'd3, 4'd5, 32'h0);
        send_access(OP_READ, 4'd3, 4'd5, 32'h0);
        send_access(OP_READ, 4'd7, 4'd9, 32'h0);
        send_access(OP_WRITE, 4'd9, 4'd1, 32'h5A5A_A5A5);
        send_access(OP_READ, 4'd9, 4'd1, 32'h0);

        // direct mapped over contents left by two-way placement
        set_mode(1'b0);
        send_access(OP_READ, 4'd1, 4'd2, 32'h0);
        send_access(OP_READ, 4'd9, 4'd4, 32'h0);
        send_access(OP_READ, 4'd15, 4'd0, 32'h0);
        send_access(OP_WRITE, 4'd6, 4'd15, 32'h1234_5678);
        send_access(OP_READ, 4'd14, 4'd14, 32'h0);
        send_access(OP_READ, 4'd6, 4'd15, 32'h0);
        send_access(OP_READ, 4'd0, 4'd8, 32'h0);

        // random phases, mode alternating
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_mode((p % 2 == 0) ? 1'b1 : 1'b0);
            repeat (PHASE_ITEMS) random_access(p);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
